[hdl/round_robin_run_queue_core_defines.svh]
// assertion macros used by the run queue sequencer
`ifndef ROUND_ROBIN_RUN_QUEUE_CORE_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_CORE_DEFINES_SVH

// property that holds at every clock edge out of reset
`define RRQ_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RRQ_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/rrq_pkg.sv]
// types and constants of the round-robin run queue
`timescale 1ns / 1ps
package rrq_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int SLICE_BITS_DEF = 10;

  localparam int CMD_W      = 3;
  localparam int TID_W      = 4;
  localparam int RELOAD_W   = 10;
  localparam int CNT_OUT_W  = 5;
  localparam int STATUS_W   = 2;

  localparam logic [RELOAD_W-1:0] RELOAD_RST = 10'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADMIT   = 3'd0,
    CMD_ENQUEUE = 3'd1,
    CMD_DEQUEUE = 3'd2,
    CMD_REQUEUE = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_PICK    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_ABSENT  = 2'd2
  } status_t;

  // memory write enables from the sequencer to the store
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic slice_we;
  } store_we_t;

  // one result beat
  typedef struct packed {
    logic [TID_W-1:0]     head_task;
    logic                 head_valid;
    logic                 resched;
    logic [CNT_OUT_W-1:0] queued_count;
    status_t              status;
  } res_t;

endpackage

[hdl/rrq_store.sv]
// link and slice memories, one write and one registered read port each
`timescale 1ns / 1ps
module rrq_store
  import rrq_pkg::*;
#(
  parameter int DEPTH      = MAX_TASKS_DEF,
  parameter int SLICE_BITS = SLICE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  store_we_t                we,
  input  logic [$clog2(DEPTH)-1:0] nx_waddr,
  input  logic [$clog2(DEPTH)-1:0] nx_wdata,
  input  logic [$clog2(DEPTH)-1:0] pv_waddr,
  input  logic [$clog2(DEPTH)-1:0] pv_wdata,
  input  logic [$clog2(DEPTH)-1:0] sl_waddr,
  input  logic [SLICE_BITS-1:0]    sl_wdata,
  output logic [$clog2(DEPTH)-1:0] nx_rd,
  output logic [$clog2(DEPTH)-1:0] pv_rd,
  output logic [SLICE_BITS-1:0]    sl_rd
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [ADDR_W-1:0]     next_mem  [DEPTH];
  logic [ADDR_W-1:0]     prev_mem  [DEPTH];
  logic [SLICE_BITS-1:0] slice_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.next_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    if (we.prev_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
    if (we.slice_we) begin
      slice_mem[sl_waddr] <= sl_wdata;
    end
    if (rd_en) begin
      nx_rd <= next_mem[rd_addr];
      pv_rd <= prev_mem[rd_addr];
      sl_rd <= slice_mem[rd_addr];
    end
  end

endmodule

[hdl/rrq_seq.sv]
// command sequencer: list pointers, membership bits and read-modify-write of the store
`timescale 1ns / 1ps
`include "round_robin_run_queue_core_defines.svh"
module rrq_seq
  import rrq_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int SLICE_BITS = SLICE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CMD_W-1:0]             in_command,
  input  logic [TID_W-1:0]             in_task_id,
  input  logic [SLICE_BITS-1:0]        reload,
  output logic                         res_valid,
  input  logic                         res_ready,
  output res_t                         res,
  output logic                         rd_en,
  output logic [$clog2(MAX_TASKS)-1:0] rd_addr,
  output store_we_t                    we,
  output logic [$clog2(MAX_TASKS)-1:0] nx_waddr,
  output logic [$clog2(MAX_TASKS)-1:0] nx_wdata,
  output logic [$clog2(MAX_TASKS)-1:0] pv_waddr,
  output logic [$clog2(MAX_TASKS)-1:0] pv_wdata,
  output logic [$clog2(MAX_TASKS)-1:0] sl_waddr,
  output logic [SLICE_BITS-1:0]        sl_wdata,
  input  logic [$clog2(MAX_TASKS)-1:0] nx_rd,
  input  logic [$clog2(MAX_TASKS)-1:0] pv_rd,
  input  logic [SLICE_BITS-1:0]        sl_rd
);

  localparam int TASK_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_APP  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [TASK_W-1:0]     tid_r, tid_nxt;
  logic                  tok_r, tok_nxt;
  logic [TASK_W-1:0]     head_r, head_nxt;
  logic [TASK_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [MAX_TASKS-1:0]  in_q_r, in_q_nxt;
  status_t               status_r, status_nxt;
  logic                  resched_r, resched_nxt;
  logic                  do_unl, do_app;
  logic [SLICE_BITS-1:0] sl_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign rd_en     = in_valid && in_ready;
  assign rd_addr   = TASK_W'(in_task_id);
  assign sl_dec    = sl_rd - SLICE_BITS'(1);

  always_comb begin
    res.head_task    = (count_r != '0) ? TID_W'(head_r) : '0;
    res.head_valid   = (count_r != '0);
    res.resched      = resched_r;
    res.queued_count = CNT_OUT_W'(count_r);
    res.status       = status_r;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    tid_nxt     = tid_r;
    tok_nxt     = tok_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    in_q_nxt    = in_q_r;
    status_nxt  = status_r;
    resched_nxt = resched_r;
    do_unl      = 1'b0;
    do_app      = 1'b0;
    we          = '0;
    nx_waddr    = '0;
    nx_wdata    = '0;
    pv_waddr    = '0;
    pv_wdata    = '0;
    sl_waddr    = tid_r;
    sl_wdata    = reload;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cmd_t'(in_command);
          tid_nxt     = TASK_W'(in_task_id);
          tok_nxt     = (32'(in_task_id) < MAX_TASKS);
          status_nxt  = ST_OK;
          resched_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // link and slice read data for tid_r is valid here
        state_nxt = S_RESP;
        if (tok_r) begin
          case (cmd_r)
            CMD_ADMIT: begin
              we.slice_we = 1'b1;
            end
            CMD_ENQUEUE: begin
              if (in_q_r[tid_r]) begin
                status_nxt = ST_ALREADY;
              end else begin
                do_app = 1'b1;
              end
            end
            CMD_DEQUEUE: begin
              if (!in_q_r[tid_r]) begin
                status_nxt = ST_ABSENT;
              end else begin
                do_unl = 1'b1;
              end
            end
            CMD_REQUEUE: begin
              if (!in_q_r[tid_r]) begin
                status_nxt = ST_ABSENT;
              end else if (count_r > CNT_W'(1)) begin
                do_unl    = 1'b1;
                state_nxt = S_APP;
              end
            end
            CMD_TICK: begin
              we.slice_we = 1'b1;
              if (sl_dec == '0) begin
                // slice expired: reload, move to tail when others wait
                if (in_q_r[tid_r] && count_r > CNT_W'(1)) begin
                  do_unl      = 1'b1;
                  resched_nxt = 1'b1;
                  state_nxt   = S_APP;
                end
              end else begin
                sl_wdata = sl_dec;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_APP: begin
        do_app    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_unl) begin
      if (tid_r == head_r) begin
        head_nxt = nx_rd;
      end else begin
        we.next_we = 1'b1;
        nx_waddr   = pv_rd;
        nx_wdata   = nx_rd;
      end
      if (tid_r == tail_r) begin
        tail_nxt = pv_rd;
      end else begin
        we.prev_we = 1'b1;
        pv_waddr   = nx_rd;
        pv_wdata   = pv_rd;
      end
      in_q_nxt[tid_r] = 1'b0;
      count_nxt       = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end

    if (do_app) begin
      if (count_r == '0) begin
        head_nxt = tid_r;
      end else begin
        we.next_we = 1'b1;
        nx_waddr   = tail_r;
        nx_wdata   = tid_r;
        we.prev_we = 1'b1;
        pv_waddr   = tid_r;
        pv_wdata   = tail_r;
      end
      tail_nxt        = tid_r;
      in_q_nxt[tid_r] = 1'b1;
      count_nxt       = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      in_q_r    <= '0;
      status_r  <= ST_OK;
      resched_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      in_q_r    <= in_q_nxt;
      status_r  <= status_nxt;
      resched_r <= resched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    tid_r <= tid_nxt;
    tok_r <= tok_nxt;
  end

  `RRQ_ALWAYS(a_count_matches_members, clk, rst_n, $countones(in_q_r) == int'(count_r), "task count differs from membership bits")
  `RRQ_IMPLIES(a_ends_are_members, clk, rst_n, count_r != '0, in_q_r[head_r] && in_q_r[tail_r], "head or tail task not queued")
  `RRQ_IMPLIES(a_single_task_ends, clk, rst_n, count_r == CNT_W'(1), head_r == tail_r, "lone task but head and tail differ")
  `RRQ_IMPLIES(a_empty_ptrs_clear, clk, rst_n, count_r == '0, head_r == '0 && tail_r == '0, "empty queue with stale pointers")

endmodule

[hdl/round_robin_run_queue_core.sv]
// top level of the round-robin run queue with per-task time slice
//
//  channel | direction | handshake         | beat contents
//  in      | in        | in_valid/in_ready | command, task id
//  out     | out       | out_valid/out_ready | head task, head valid, resched, count, status
//  cfg     | in        | cfg_we            | slice reload value
//
// an item is taken only while the sequencer is idle; a requeue or an expiring tick that
// moves a task to the tail adds an append step, every other command goes straight to respond
// the extra step is set by the registered link memory read and the single write port per link
// memory, so unlink and append go in separate cycles
// a result waiting in the output register holds the sequencer in its respond step
// reset clears membership bits and pointers at once; the memories need no clearing pass
`timescale 1ns / 1ps
module round_robin_run_queue_core
  import rrq_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int SLICE_BITS = SLICE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [TID_W-1:0]     in_task_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TID_W-1:0]     out_head_task,
  output logic                 out_head_valid,
  output logic                 out_resched,
  output logic [CNT_OUT_W-1:0] out_queued_count,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [RELOAD_W-1:0]  cfg_slice_reload
);

  localparam int TASK_W = $clog2(MAX_TASKS);

  logic [RELOAD_W-1:0]   reload_r;
  logic                  out_valid_r;
  res_t                  res_r;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic [SLICE_BITS-1:0] reload;
  logic                  rd_en;
  logic [TASK_W-1:0]     rd_addr;
  store_we_t             we;
  logic [TASK_W-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata, sl_waddr;
  logic [SLICE_BITS-1:0] sl_wdata;
  logic [TASK_W-1:0]     nx_rd, pv_rd;
  logic [SLICE_BITS-1:0] sl_rd;

  assign reload    = SLICE_BITS'(reload_r);
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RST;
    end else if (cfg_we) begin
      reload_r <= cfg_slice_reload;
    end
  end

  // output register parts the result beat from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_head_task    = res_r.head_task;
  assign out_head_valid   = res_r.head_valid;
  assign out_resched      = res_r.resched;
  assign out_queued_count = res_r.queued_count;
  assign out_status       = res_r.status;

  rrq_seq #(
    .MAX_TASKS  (MAX_TASKS),
    .SLICE_BITS (SLICE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_task_id (in_task_id),
    .reload     (reload),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .we         (we),
    .nx_waddr   (nx_waddr),
    .nx_wdata   (nx_wdata),
    .pv_waddr   (pv_waddr),
    .pv_wdata   (pv_wdata),
    .sl_waddr   (sl_waddr),
    .sl_wdata   (sl_wdata),
    .nx_rd      (nx_rd),
    .pv_rd      (pv_rd),
    .sl_rd      (sl_rd)
  );

  rrq_store #(
    .DEPTH      (MAX_TASKS),
    .SLICE_BITS (SLICE_BITS)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .we       (we),
    .nx_waddr (nx_waddr),
    .nx_wdata (nx_wdata),
    .pv_waddr (pv_waddr),
    .pv_wdata (pv_wdata),
    .sl_waddr (sl_waddr),
    .sl_wdata (sl_wdata),
    .nx_rd    (nx_rd),
    .pv_rd    (pv_rd),
    .sl_rd    (sl_rd)
  );

endmodule

[tb/rrq_sched_checker.sv]
// run queue checker: mirrors the scheduler state and checks every result beat
`timescale 1ns / 1ps
module rrq_sched_checker
  import rrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [TID_W-1:0]     in_task_id,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [TID_W-1:0]     out_head_task,
  input  logic                 out_head_valid,
  input  logic                 out_resched,
  input  logic [CNT_OUT_W-1:0] out_queued_count,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [RELOAD_W-1:0]  cfg_slice_reload,
  output int                   results_owed,
  output int                   fail_count
);

  logic [TID_W-1:0]          link_next [MAX_TASKS_DEF];
  logic [TID_W-1:0]          link_prev [MAX_TASKS_DEF];
  logic                      queued    [MAX_TASKS_DEF];
  logic [SLICE_BITS_DEF-1:0] slice_cnt [MAX_TASKS_DEF];
  logic [TID_W-1:0]          run_head;
  logic [TID_W-1:0]          run_tail;
  logic [CNT_OUT_W-1:0]      run_len;
  logic [RELOAD_W-1:0]       reload_val;

  // queue view after each accepted command, oldest first
  res_t queue_snapshots [$];

  task automatic drop_from_list(input logic [TID_W-1:0] t);
    logic [TID_W-1:0] nx;
    logic [TID_W-1:0] pv;
    nx = link_next[t];
    pv = link_prev[t];
    if (t == run_head) run_head = nx;
    else link_next[pv] = nx;
    if (t == run_tail) run_tail = pv;
    else link_prev[nx] = pv;
    queued[t] = 1'b0;
    if (run_len != '0) run_len = run_len - CNT_OUT_W'(1);
    if (run_len == '0) begin
      run_head = '0;
      run_tail = '0;
    end
  endtask

  task automatic add_at_tail(input logic [TID_W-1:0] t);
    if (run_len == '0) begin
      run_head = t;
    end else begin
      link_next[run_tail] = t;
      link_prev[t] = run_tail;
    end
    run_tail = t;
    link_next[t] = t;
    queued[t] = 1'b1;
    run_len = run_len + CNT_OUT_W'(1);
  endtask

  task automatic run_sched_cmd(input logic [CMD_W-1:0] c, input logic [TID_W-1:0] t,
                               output res_t r);
    status_t st;
    logic    moved;
    st = ST_OK;
    moved = 1'b0;
    case (c)
      CMD_ADMIT: slice_cnt[t] = reload_val;
      CMD_ENQUEUE: begin
        if (queued[t]) st = ST_ALREADY;
        else add_at_tail(t);
      end
      CMD_DEQUEUE: begin
        if (!queued[t]) st = ST_ABSENT;
        else drop_from_list(t);
      end
      CMD_REQUEUE: begin
        if (!queued[t]) begin
          st = ST_ABSENT;
        end else if (run_len > 1) begin
          drop_from_list(t);
          add_at_tail(t);
        end
      end
      CMD_TICK: begin
        slice_cnt[t] = slice_cnt[t] - SLICE_BITS_DEF'(1);
        if (slice_cnt[t] == '0) begin
          slice_cnt[t] = reload_val;
          // expiry only rotates when someone else is waiting
          if (queued[t] && run_len > 1) begin
            drop_from_list(t);
            add_at_tail(t);
            moved = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.head_task    = (run_len != '0) ? run_head : '0;
    r.head_valid   = (run_len != '0);
    r.resched      = moved;
    r.queued_count = run_len;
    r.status       = st;
  endtask

  always @(posedge clk) begin
    res_t want;
    int   nbad;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS_DEF; i++) begin
        link_next[i] = '0;
        link_prev[i] = '0;
        queued[i]    = 1'b0;
        slice_cnt[i] = '0;
      end
      run_head   = '0;
      run_tail   = '0;
      run_len    = '0;
      reload_val = RELOAD_RST;
      queue_snapshots.delete();
      results_owed <= 0;
      fail_count   <= 0;
    end else begin
      nbad = 0;
      if (in_valid && in_ready) begin
        run_sched_cmd(in_command, in_task_id, want);
        queue_snapshots.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (queue_snapshots.size() == 0) begin
          $error("result beat with no command outstanding: head_task %0d", out_head_task);
          nbad++;
        end else begin
          want = queue_snapshots.pop_front();
          if (out_head_task !== want.head_task) begin
            $error("head_task expected %0d actual %0d", want.head_task, out_head_task);
            nbad++;
          end
          if (out_head_valid !== want.head_valid) begin
            $error("head_valid expected %0d actual %0d", want.head_valid, out_head_valid);
            nbad++;
          end
          if (out_resched !== want.resched) begin
            $error("resched expected %0d actual %0d", want.resched, out_resched);
            nbad++;
          end
          if (out_queued_count !== want.queued_count) begin
            $error("queued_count expected %0d actual %0d", want.queued_count,
                   out_queued_count);
            nbad++;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            nbad++;
          end
        end
      end
      if (cfg_we) reload_val = cfg_slice_reload;
      results_owed <= queue_snapshots.size();
      fail_count   <= fail_count + nbad;
    end
  end

endmodule

[tb/tb_round_robin_run_queue_core.sv]
// testbench top: stimulus, handshake pacing and verdict for the run queue core
`timescale 1ns / 1ps
module tb_round_robin_run_queue_core;
  import rrq_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_CMDS  = 275;
  localparam int NUM_PHASES  = 6;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = '0;
  logic [TID_W-1:0]     in_task_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TID_W-1:0]     out_head_task;
  logic                 out_head_valid;
  logic                 out_resched;
  logic [CNT_OUT_W-1:0] out_queued_count;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we = 1'b0;
  logic [RELOAD_W-1:0]  cfg_slice_reload = RELOAD_RST;

  int results_owed;
  int fail_count;
  int stall_cycles = 0;

  // what the sender believes about admitted and queued tasks
  logic [MAX_TASKS_DEF-1:0] admitted = '0;
  logic [MAX_TASKS_DEF-1:0] in_list  = '0;

  logic [1:0] rx_mode = '0;
  int         rx_left = 0;
  logic [3:0] rx_phase = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  round_robin_run_queue_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_head_task    (out_head_task),
    .out_head_valid   (out_head_valid),
    .out_resched      (out_resched),
    .out_queued_count (out_queued_count),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_slice_reload (cfg_slice_reload)
  );

  rrq_sched_checker u_sched_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_head_task    (out_head_task),
    .out_head_valid   (out_head_valid),
    .out_resched      (out_resched),
    .out_queued_count (out_queued_count),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_slice_reload (cfg_slice_reload),
    .results_owed     (results_owed),
    .fail_count       (fail_count)
  );

  // receiver switches between full rate, random, periodic and heavy stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left   <= 0;
    end else begin
      rx_phase <= rx_phase + 4'd1;
      if (rx_left == 0) begin
        rx_mode <= 2'($urandom_range(0, 3));
        rx_left <= $urandom_range(32, 256);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready <= (rx_phase[1:0] != 2'b11);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("round_robin_run_queue_core: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_sched_cmd(input logic [CMD_W-1:0] c, input logic [TID_W-1:0] t);
    in_valid   <= 1'b1;
    in_command <= c;
    in_task_id <= t;
    case (c)
      CMD_ADMIT:   admitted[t] = 1'b1;
      CMD_ENQUEUE: in_list[t] = 1'b1;
      CMD_DEQUEUE: in_list[t] = 1'b0;
      default: ;
    endcase
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // block is idle once every result is back and the sequencer has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reload(input logic [RELOAD_W-1:0] v);
    cfg_we           <= 1'b1;
    cfg_slice_reload <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TID_W-1:0] pick_task(input logic [MAX_TASKS_DEF-1:0] mask);
    int start;
    int idx;
    start = $urandom_range(0, MAX_TASKS_DEF - 1);
    for (int i = 0; i < MAX_TASKS_DEF; i++) begin
      idx = (start + i) % MAX_TASKS_DEF;
      if (mask[idx]) return TID_W'(idx);
    end
    return TID_W'(start);
  endfunction

  task automatic choose_sched_cmd(input bit fill, output logic [CMD_W-1:0] c,
                                  output logic [TID_W-1:0] t);
    int r;
    int enq_end;
    int deq_end;
    logic [MAX_TASKS_DEF-1:0] mask;
    r = $urandom_range(0, 99);
    enq_end = fill ? 38 : 24;
    deq_end = fill ? 46 : 44;
    t = TID_W'($urandom_range(0, MAX_TASKS_DEF - 1));
    if (r < 8) begin
      c = CMD_ADMIT;
    end else if (r < enq_end) begin
      c = CMD_ENQUEUE;
      if ($urandom_range(0, 99) < 85) t = pick_task(~in_list);
    end else if (r < deq_end) begin
      c = CMD_DEQUEUE;
      if ($urandom_range(0, 99) < 85) t = pick_task(in_list);
    end else if (r < 58) begin
      c = CMD_REQUEUE;
      if ($urandom_range(0, 99) < 85) t = pick_task(in_list);
    end else if (r < 90) begin
      // ticks only go to tasks whose slice has been loaded
      if (admitted == '0) begin
        c = CMD_ADMIT;
      end else begin
        c = CMD_TICK;
        mask = admitted;
        if ($urandom_range(0, 3) != 0 && (admitted & in_list) != '0) mask = admitted & in_list;
        t = pick_task(mask);
      end
    end else if (r < 97) begin
      c = CMD_PICK;
    end else begin
      c = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
  endtask

  initial begin
    logic [RELOAD_W-1:0] reload_plan [NUM_PHASES];
    logic [CMD_W-1:0]    c;
    logic [TID_W-1:0]    t;
    int                  sent;
    int                  burst;
    bit                  fill;

    reload_plan = '{10'd1023, 10'd1, 10'd2, 10'd3, 10'd10, 10'd1};
    reload_plan[NUM_PHASES-1] = RELOAD_W'($urandom_range(4, 40));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset reload value: empty queue, error cases, lone task, middle unlink
    send_sched_cmd(CMD_PICK, 4'd0);
    send_sched_cmd(CMD_DEQUEUE, 4'd5);
    send_sched_cmd(CMD_REQUEUE, 4'd5);
    send_sched_cmd(CMD_ADMIT, 4'd0);
    send_sched_cmd(CMD_ADMIT, 4'd15);
    send_sched_cmd(CMD_ENQUEUE, 4'd0);
    send_sched_cmd(CMD_ENQUEUE, 4'd0);
    send_sched_cmd(CMD_REQUEUE, 4'd0);
    send_sched_cmd(CMD_TICK, 4'd15);
    send_sched_cmd(CMD_TICK, 4'd0);
    send_sched_cmd(CMD_ENQUEUE, 4'd15);
    send_sched_cmd(CMD_ADMIT, 4'd7);
    send_sched_cmd(CMD_ENQUEUE, 4'd7);
    send_sched_cmd(CMD_REQUEUE, 4'd0);
    send_sched_cmd(CMD_DEQUEUE, 4'd7);
    send_sched_cmd(CMD_PICK, 4'd15);
    send_sched_cmd(CMD_SPARE_6, 4'd9);

    // reload value of one: these ticks hit slices loaded before, so none of them expires
    drain_results();
    write_reload(10'd1);
    send_sched_cmd(CMD_TICK, 4'd0);
    send_sched_cmd(CMD_TICK, 4'd15);
    send_sched_cmd(CMD_SPARE_7, 4'd15);
    send_sched_cmd(CMD_DEQUEUE, 4'd0);
    send_sched_cmd(CMD_DEQUEUE, 4'd15);
    send_sched_cmd(CMD_TICK, 4'd15);

    // zero reload: slice wraps instead of expiring
    drain_results();
    write_reload(10'd0);
    send_sched_cmd(CMD_ADMIT, 4'd3);
    send_sched_cmd(CMD_TICK, 4'd3);
    send_sched_cmd(CMD_ENQUEUE, 4'd3);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_reload(reload_plan[ph]);
      sent = 0;
      while (sent < PHASE_CMDS) begin
        burst = $urandom_range(1, 40);
        fill  = $urandom_range(0, 1);
        for (int k = 0; k < burst && sent < PHASE_CMDS; k++) begin
          choose_sched_cmd(fill, c, t);
          send_sched_cmd(c, t);
          sent++;
          if (ph == 2 && sent == 130) drain_results();
        end
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("round_robin_run_queue_core: match");
    end else begin
      $display("round_robin_run_queue_core: mismatch");
    end
    $finish;
  end

endmodule
